FILE: src/pngi_pkg.sv
// Shared constants, types and helpers of the proportional-navigation guidance block.
package pngi_pkg;

    localparam int DW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int GAIN_FRAC = 8;
    localparam int STEP_FRAC = 16;
    localparam int GAIN_W    = 16;
    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int RV_W   = DW + 1;
    localparam int D_W    = 2 * RV_W;
    localparam int C_W    = 2 * RV_W + 1;
    localparam int MA_W   = 2 * RV_W + 2;
    localparam int MB_W   = RV_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int NUM_W  = D_W + FRAC_BITS;
    localparam int Q_W    = DW + 1;

    localparam logic [CFG_IDX_W-1:0] REG_NAV_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_VEL_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_VEL_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_VEL_Z = 3'd7;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd768;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic              load;
        logic              start;
        logic              neg;
        logic [ACC_W-1:0]  init;
        logic [MA_W-1:0]   a;
        logic [MB_W-1:0]   b;
    } t_mac_cmd;

    function automatic logic [DW-1:0] sat32(input logic [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:DW-1]) | ~(|v[ACC_W-1:DW-1]);
        if (fits) begin
            return v[DW-1:0];
        end
        return v[ACC_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

endpackage

FILE: src/pngi_mac.sv
// Bit-serial signed multiply-accumulate unit with accumulator preload.
module pngi_mac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pngi_pkg::t_mac_cmd             i_cmd,
    output logic                           o_done,
    output logic signed [pngi_pkg::ACC_W-1:0] o_acc
);

    localparam int CNT_W = $clog2(pngi_pkg::MB_W);

    logic [pngi_pkg::MA_W-1:0]  r_ma;
    logic [pngi_pkg::MA_W-1:0]  r_hi;
    logic [pngi_pkg::MB_W-1:0]  r_lo;
    logic                       r_sgn;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_run;
    logic                       r_fin;
    logic                       r_done;
    logic signed [pngi_pkg::ACC_W-1:0] r_acc;

    logic signed [pngi_pkg::MA_W-1:0] a_s;
    logic signed [pngi_pkg::MB_W-1:0] b_s;
    logic [pngi_pkg::MA_W-1:0]  a_mag;
    logic [pngi_pkg::MB_W-1:0]  b_mag;
    logic [pngi_pkg::MA_W:0]    sum;
    logic [pngi_pkg::ACC_W-1:0] prod;

    assign a_s   = $signed(i_cmd.a);
    assign b_s   = $signed(i_cmd.b);
    assign a_mag = a_s[pngi_pkg::MA_W-1] ? pngi_pkg::MA_W'(-a_s) : i_cmd.a;
    assign b_mag = b_s[pngi_pkg::MB_W-1] ? pngi_pkg::MB_W'(-b_s) : i_cmd.b;
    assign sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_ma} : '0);
    assign prod  = pngi_pkg::ACC_W'({r_hi, r_lo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.load) begin
                r_acc <= $signed(i_cmd.init);
            end
            if (i_cmd.start) begin
                r_ma  <= a_mag;
                r_hi  <= '0;
                r_lo  <= b_mag;
                r_sgn <= a_s[pngi_pkg::MA_W-1] ^ b_s[pngi_pkg::MB_W-1] ^ i_cmd.neg;
                r_cnt <= CNT_W'(pngi_pkg::MB_W - 1);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_hi <= sum[pngi_pkg::MA_W:1];
                r_lo <= {sum[0], r_lo[pngi_pkg::MB_W-1:1]};
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (r_fin) begin
                r_acc  <= r_sgn ? r_acc - $signed(prod) : r_acc + $signed(prod);
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

FILE: src/pngi_div.sv
// Bit-serial restoring divider for the line-of-sight rate, saturated to 32 bits.
module pngi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_neg,
    input  logic [pngi_pkg::D_W-1:0]    i_mag,
    input  logic [pngi_pkg::D_W-1:0]    i_den,
    output logic                        o_done,
    output logic [pngi_pkg::DW-1:0]     o_w
);

    localparam int CNT_W = $clog2(pngi_pkg::NUM_W);

    logic [pngi_pkg::NUM_W-1:0] r_num;
    logic [pngi_pkg::D_W-1:0]   r_rem;
    logic [pngi_pkg::Q_W-1:0]   r_q;
    logic                       r_ovf;
    logic                       r_neg;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_run;
    logic                       r_done;

    logic [pngi_pkg::D_W:0]     trial;
    logic                       ge;
    logic [pngi_pkg::D_W:0]     diff;
    logic                       big_pos;
    logic                       big_neg;

    assign trial = {r_rem, r_num[pngi_pkg::NUM_W-1]};
    assign ge    = trial >= {1'b0, i_den};
    assign diff  = trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= {i_mag, {pngi_pkg::FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
                r_neg <= i_neg;
                r_cnt <= CNT_W'(pngi_pkg::NUM_W - 1);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_num <= {r_num[pngi_pkg::NUM_W-2:0], 1'b0};
                r_rem <= ge ? diff[pngi_pkg::D_W-1:0] : trial[pngi_pkg::D_W-1:0];
                r_q   <= {r_q[pngi_pkg::Q_W-2:0], ge};
                r_ovf <= r_ovf | r_q[pngi_pkg::Q_W-1];
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign big_pos = r_ovf | r_q[pngi_pkg::DW] | r_q[pngi_pkg::DW-1];
    assign big_neg = r_ovf | r_q[pngi_pkg::DW]
                   | (r_q[pngi_pkg::DW-1] & (|r_q[pngi_pkg::DW-2:0]));

    always_comb begin
        if (r_neg) begin
            o_w = big_neg ? pngi_pkg::SAT_MIN : pngi_pkg::DW'(-r_q[pngi_pkg::DW-1:0]);
        end else begin
            o_w = big_pos ? pngi_pkg::SAT_MAX : r_q[pngi_pkg::DW-1:0];
        end
    end

    assign o_done = r_done;

endmodule

FILE: src/pn_guidance_integrator.sv
// Top level of the proportional-navigation guidance block with state integration.
//
// Input stream (s_axis): one transaction per guidance step. tuser carries mode
// (0 guidance step, 1 load own state from the start registers); tdata carries
// the target position and velocity, Q16.16. Output stream (m_axis): one
// transaction per input, with the acceleration command, the new own velocity
// and position in tdata and the zero-range flag in tuser.
// Configuration: write i_cfg_we with i_cfg_idx / i_cfg_data while idle.
// A guidance step runs 24 multiply-accumulate passes on one bit-serial unit
// (one operand bit per cycle) and three serial divisions.
// A zero range skips the divisions and the command passes.
// One item is in work at a time; the next is taken once the result is in the
// output register, so a stalled receiver holds at most one result and the
// block then waits before writing the next one.
// Reset returns the registers to their defaults and own state to zero.
module pn_guidance_integrator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // target_pos_x, target_pos_y, target_pos_z, target_vel_x, target_vel_y, target_vel_z
    input  logic [191:0]  i_s_axis_tdata,
    // mode
    input  logic [0:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // accel_x/y/z, new_vel_x/y/z, new_pos_x/y/z
    output logic [287:0]  o_m_axis_tdata,
    // range_zero
    output logic [0:0]    o_m_axis_tuser,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    localparam int DW = pngi_pkg::DW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_MAC, ST_DIV_GO, ST_DIV, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_RSQ, PH_CROSS, PH_VW, PH_GAIN, PH_VEL, PH_POS
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic [1:0] r_idx;
    logic       r_half;

    logic [pngi_pkg::GAIN_W-1:0] r_gain;
    logic [pngi_pkg::STEP_W-1:0] r_ts;
    logic signed [DW-1:0] r_start_pos [3];
    logic signed [DW-1:0] r_start_vel [3];
    logic signed [DW-1:0] r_pos [3];
    logic signed [DW-1:0] r_vel [3];
    logic signed [pngi_pkg::RV_W-1:0] r_r [3];
    logic signed [pngi_pkg::RV_W-1:0] r_v [3];
    logic [pngi_pkg::D_W-1:0]        r_d;
    logic signed [pngi_pkg::C_W-1:0] r_c [3];
    logic signed [DW-1:0] r_w [3];
    logic signed [pngi_pkg::MA_W-1:0] r_x;
    logic signed [DW-1:0] r_cmd [3];
    logic       r_flag;
    logic       r_out_valid;
    logic [287:0] r_out_data;
    logic       r_out_user;

    pngi_pkg::t_mac_cmd mac_cmd;
    logic mac_done;
    logic signed [pngi_pkg::ACC_W-1:0] mac_acc;
    logic signed [pngi_pkg::ACC_W-1:0] acc_cmd;
    logic signed [pngi_pkg::ACC_W-1:0] acc_step;

    logic div_start;
    logic div_done;
    logic [DW-1:0] div_w;
    logic signed [pngi_pkg::C_W-1:0] c_sel;
    logic [pngi_pkg::C_W-1:0] c_mag;

    logic [1:0] ia;
    logic [1:0] ib;
    logic s_acc;
    logic out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc    = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        case (r_idx)
            2'd0: begin
                ia = 2'd1;
                ib = 2'd2;
            end
            2'd1: begin
                ia = 2'd2;
                ib = 2'd0;
            end
            default: begin
                ia = 2'd0;
                ib = 2'd1;
            end
        endcase
    end

    always_comb begin
        mac_cmd = '0;
        if (r_state == ST_ISSUE) begin
            mac_cmd.start = 1'b1;
            case (r_phase)
                PH_RSQ: begin
                    mac_cmd.load = (r_idx == 2'd0);
                    mac_cmd.a    = pngi_pkg::MA_W'(r_r[r_idx]);
                    mac_cmd.b    = pngi_pkg::MB_W'(r_r[r_idx]);
                end
                PH_CROSS: begin
                    mac_cmd.load = !r_half;
                    mac_cmd.neg  = r_half;
                    mac_cmd.a    = pngi_pkg::MA_W'(r_half ? r_r[ib] : r_r[ia]);
                    mac_cmd.b    = pngi_pkg::MB_W'(r_half ? r_v[ia] : r_v[ib]);
                end
                PH_VW: begin
                    mac_cmd.load = !r_half;
                    mac_cmd.neg  = r_half;
                    mac_cmd.a    = pngi_pkg::MA_W'(r_half ? r_v[ib] : r_v[ia]);
                    mac_cmd.b    = pngi_pkg::MB_W'(r_half ? r_w[ia] : r_w[ib]);
                end
                PH_GAIN: begin
                    mac_cmd.load = 1'b1;
                    mac_cmd.a    = r_x;
                    mac_cmd.b    = pngi_pkg::MB_W'(r_gain);
                end
                PH_VEL: begin
                    mac_cmd.load = 1'b1;
                    mac_cmd.init = pngi_pkg::ACC_W'(r_vel[r_idx]) <<< pngi_pkg::STEP_FRAC;
                    mac_cmd.a    = pngi_pkg::MA_W'(r_cmd[r_idx]);
                    mac_cmd.b    = pngi_pkg::MB_W'(r_ts);
                end
                PH_POS: begin
                    mac_cmd.load = 1'b1;
                    mac_cmd.init = pngi_pkg::ACC_W'(r_pos[r_idx]) <<< pngi_pkg::STEP_FRAC;
                    mac_cmd.a    = pngi_pkg::MA_W'(r_vel[r_idx]);
                    mac_cmd.b    = pngi_pkg::MB_W'(r_ts);
                end
                default: begin
                    mac_cmd.start = 1'b0;
                end
            endcase
        end
    end

    pngi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    assign acc_cmd  = mac_acc >>> (pngi_pkg::FRAC_BITS + pngi_pkg::GAIN_FRAC);
    assign acc_step = mac_acc >>> pngi_pkg::STEP_FRAC;

    assign div_start = (r_state == ST_DIV_GO);
    assign c_sel     = r_c[r_idx];
    assign c_mag     = c_sel[pngi_pkg::C_W-1] ? pngi_pkg::C_W'(-c_sel) : c_sel;

    pngi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_neg   (c_sel[pngi_pkg::C_W-1]),
        .i_mag   (c_mag[pngi_pkg::D_W-1:0]),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_w     (div_w)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_RSQ;
            r_idx       <= 2'd0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
            r_gain      <= pngi_pkg::GAIN_RESET;
            r_ts        <= pngi_pkg::STEP_RESET;
            for (int i = 0; i < 3; i++) begin
                r_start_pos[i] <= '0;
                r_start_vel[i] <= '0;
                r_pos[i]       <= '0;
                r_vel[i]       <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pngi_pkg::REG_NAV_GAIN:    r_gain <= i_cfg_data[pngi_pkg::GAIN_W-1:0];
                    pngi_pkg::REG_TIME_STEP:   r_ts   <= i_cfg_data[pngi_pkg::STEP_W-1:0];
                    pngi_pkg::REG_START_POS_X: r_start_pos[0] <= i_cfg_data;
                    pngi_pkg::REG_START_POS_Y: r_start_pos[1] <= i_cfg_data;
                    pngi_pkg::REG_START_POS_Z: r_start_pos[2] <= i_cfg_data;
                    pngi_pkg::REG_START_VEL_X: r_start_vel[0] <= i_cfg_data;
                    pngi_pkg::REG_START_VEL_Y: r_start_vel[1] <= i_cfg_data;
                    pngi_pkg::REG_START_VEL_Z: r_start_vel[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_flag <= 1'b0;
                        if (i_s_axis_tuser[0]) begin
                            for (int i = 0; i < 3; i++) begin
                                r_pos[i] <= r_start_pos[i];
                                r_vel[i] <= r_start_vel[i];
                                r_cmd[i] <= '0;
                            end
                            r_state <= ST_DONE;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_r[i] <= pngi_pkg::RV_W'($signed(i_s_axis_tdata[DW*i +: DW]))
                                        - pngi_pkg::RV_W'(r_pos[i]);
                                r_v[i] <= pngi_pkg::RV_W'($signed(i_s_axis_tdata[DW*(i+3) +: DW]))
                                        - pngi_pkg::RV_W'(r_vel[i]);
                            end
                            r_phase <= PH_RSQ;
                            r_idx   <= 2'd0;
                            r_half  <= 1'b0;
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    if (mac_done) begin
                        case (r_phase)
                            PH_RSQ: begin
                                r_state <= ST_ISSUE;
                                if (r_idx == 2'd2) begin
                                    r_d     <= mac_acc[pngi_pkg::D_W-1:0];
                                    r_phase <= PH_CROSS;
                                    r_idx   <= 2'd0;
                                end else begin
                                    r_idx <= r_idx + 2'd1;
                                end
                            end
                            PH_CROSS: begin
                                if (!r_half) begin
                                    r_half  <= 1'b1;
                                    r_state <= ST_ISSUE;
                                end else begin
                                    r_half       <= 1'b0;
                                    r_c[r_idx]   <= mac_acc[pngi_pkg::C_W-1:0];
                                    if (r_idx == 2'd2) begin
                                        r_idx <= 2'd0;
                                        if (r_d == '0) begin
                                            r_flag <= 1'b1;
                                            for (int i = 0; i < 3; i++) begin
                                                r_cmd[i] <= '0;
                                            end
                                            r_phase <= PH_VEL;
                                            r_state <= ST_ISSUE;
                                        end else begin
                                            r_state <= ST_DIV_GO;
                                        end
                                    end else begin
                                        r_idx   <= r_idx + 2'd1;
                                        r_state <= ST_ISSUE;
                                    end
                                end
                            end
                            PH_VW: begin
                                r_state <= ST_ISSUE;
                                if (!r_half) begin
                                    r_half <= 1'b1;
                                end else begin
                                    r_half  <= 1'b0;
                                    r_x     <= mac_acc[pngi_pkg::MA_W-1:0];
                                    r_phase <= PH_GAIN;
                                end
                            end
                            PH_GAIN: begin
                                r_state      <= ST_ISSUE;
                                r_cmd[r_idx] <= pngi_pkg::sat32(acc_cmd);
                                if (r_idx == 2'd2) begin
                                    r_idx   <= 2'd0;
                                    r_phase <= PH_VEL;
                                end else begin
                                    r_idx   <= r_idx + 2'd1;
                                    r_phase <= PH_VW;
                                end
                            end
                            PH_VEL: begin
                                r_state      <= ST_ISSUE;
                                r_vel[r_idx] <= pngi_pkg::sat32(acc_step);
                                r_phase      <= PH_POS;
                            end
                            PH_POS: begin
                                r_pos[r_idx] <= pngi_pkg::sat32(acc_step);
                                if (r_idx == 2'd2) begin
                                    r_state <= ST_DONE;
                                end else begin
                                    r_idx   <= r_idx + 2'd1;
                                    r_phase <= PH_VEL;
                                    r_state <= ST_ISSUE;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DIV_GO: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_w[r_idx] <= div_w;
                        if (r_idx == 2'd2) begin
                            r_idx   <= 2'd0;
                            r_half  <= 1'b0;
                            r_phase <= PH_VW;
                            r_state <= ST_ISSUE;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= ST_DIV_GO;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_data  <= {r_pos[2], r_pos[1], r_pos[0],
                                        r_vel[2], r_vel[1], r_vel[0],
                                        r_cmd[2], r_cmd[1], r_cmd[0]};
                        r_out_user  <= r_flag;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_user;

endmodule
